[rtl/rplu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rplu_pkg
// Shared types and constants of the register preset list loader.
// ----------------------------------------------------------------------------
package rplu_pkg;

  localparam int unsigned RegCountDef   = 64;
  localparam int unsigned MaxEntriesDef = 256;
  localparam logic [14:0] RegBaseReset  = 15'd8448;

  localparam int unsigned SlotMaxW = 8;
  localparam int unsigned CountW   = 7;

  localparam logic [1:0] CmdStart = 2'd0;
  localparam logic [1:0] CmdByte  = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HDR_LO = 3'd1,
    PH_HDR_HI = 3'd2,
    PH_DATA1  = 3'd3,
    PH_DATA2  = 3'd4,
    PH_DONE   = 3'd5,
    PH_ERROR  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_END     = 3'd1,
    ST_BADADDR = 3'd2,
    ST_LIMIT   = 3'd3,
    ST_IGNORED = 3'd4,
    ST_HIT     = 3'd5,
    ST_MISS    = 3'd6
  } status_e;

  typedef struct packed {
    logic                clear;
    logic                wr_en;
    logic [SlotMaxW-1:0] wr_slot;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [SlotMaxW-1:0] rd_slot;
  } store_op_t;

  typedef struct packed {
    logic wr_written;
    logic rd_written;
  } store_flags_t;

  typedef struct packed {
    status_e           status;
    logic              hit;
    logic [CountW-1:0] count;
  } result_t;

endpackage
`default_nettype wire

[rtl/rplu_regfile.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rplu_regfile
// Shadow register values in a synchronous memory, written marks in flops.
// ----------------------------------------------------------------------------
module rplu_regfile #(
  parameter int unsigned REG_COUNT = rplu_pkg::RegCountDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rplu_pkg::store_op_t   op_i,
  output rplu_pkg::store_flags_t     flags_o,
  output logic [7:0]                 rd_data_o
);

  localparam int unsigned SlotW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [7:0]           mem_q [REG_COUNT];
  logic [7:0]           rd_data_q;
  logic [REG_COUNT-1:0] written_q;
  logic [SlotW-1:0]     wr_slot;
  logic [SlotW-1:0]     rd_slot;

  assign wr_slot = op_i.wr_slot[SlotW-1:0];
  assign rd_slot = op_i.rd_slot[SlotW-1:0];

  always_ff @(posedge clk_i) begin
    if (op_i.wr_en) begin
      mem_q[wr_slot] <= op_i.wr_data;
    end
    if (op_i.rd_en) begin
      rd_data_q <= mem_q[rd_slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (op_i.clear) begin
      written_q <= '0;
    end else if (op_i.wr_en) begin
      written_q[wr_slot] <= 1'b1;
    end
  end

  assign flags_o.wr_written = written_q[wr_slot];
  assign flags_o.rd_written = written_q[rd_slot];
  assign rd_data_o          = rd_data_q;

endmodule
`default_nettype wire

[rtl/rplu_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rplu_parser
// Record parser: header and data phases, window check, entry and write counts.
// ----------------------------------------------------------------------------
module rplu_parser #(
  parameter int unsigned REG_COUNT   = rplu_pkg::RegCountDef,
  parameter int unsigned MAX_ENTRIES = rplu_pkg::MaxEntriesDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic [1:0]             cmd_i,
  input  wire logic [7:0]             byte_i,
  input  wire logic [15:0]            qaddr_i,
  input  wire logic [14:0]            reg_base_i,
  input  wire rplu_pkg::store_flags_t flags_i,
  output rplu_pkg::store_op_t         op_o,
  output rplu_pkg::result_t           result_o
);

  localparam int unsigned EntW = $clog2(MAX_ENTRIES + 1);

  rplu_pkg::phase_e            phase_q, phase_d;
  logic [14:0]                 latch_q, latch_d;
  logic                        pair_q, pair_d;
  logic [EntW-1:0]             entry_q, entry_d;
  logic [rplu_pkg::CountW-1:0] total_q, total_d;

  logic [15:0] hdr;
  logic [15:0] wr_addr;
  logic [16:0] wr_off;
  logic [16:0] rd_off;
  logic        wr_in;
  logic        rd_in;
  logic [EntW-1:0] entry_inc;
  logic        limit;
  logic        is_byte;

  assign is_byte   = (cmd_i == rplu_pkg::CmdByte);
  assign hdr       = {byte_i, latch_q[7:0]};
  // second data byte goes to address+1, formed in 16 bits
  assign wr_addr   = (phase_q == rplu_pkg::PH_DATA2) ? ({1'b0, latch_q} + 16'd1)
                                                     : {1'b0, latch_q};
  assign wr_off    = {1'b0, wr_addr} - {2'b00, reg_base_i};
  assign rd_off    = {1'b0, qaddr_i} - {2'b00, reg_base_i};
  assign wr_in     = !wr_off[16] && (wr_off[15:0] < 16'(REG_COUNT));
  assign rd_in     = !rd_off[16] && (rd_off[15:0] < 16'(REG_COUNT));
  assign entry_inc = entry_q + EntW'(1);
  assign limit     = (entry_inc >= EntW'(MAX_ENTRIES));

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (cmd_i == rplu_pkg::CmdStart) begin
      phase_d = rplu_pkg::PH_HDR_LO;
    end else if (is_byte) begin
      unique case (phase_q)
        rplu_pkg::PH_HDR_LO: phase_d = rplu_pkg::PH_HDR_HI;
        rplu_pkg::PH_HDR_HI: begin
          phase_d = (hdr == 16'd0) ? rplu_pkg::PH_DONE : rplu_pkg::PH_DATA1;
        end
        rplu_pkg::PH_DATA1: begin
          if (!wr_in) begin
            phase_d = rplu_pkg::PH_ERROR;
          end else if (pair_q) begin
            phase_d = rplu_pkg::PH_DATA2;
          end else begin
            phase_d = limit ? rplu_pkg::PH_ERROR : rplu_pkg::PH_HDR_LO;
          end
        end
        rplu_pkg::PH_DATA2: begin
          if (!wr_in || limit) begin
            phase_d = rplu_pkg::PH_ERROR;
          end else begin
            phase_d = rplu_pkg::PH_HDR_LO;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // outputs and datapath updates
  always_comb begin
    rplu_pkg::status_e status;
    logic              wr_en;
    status  = rplu_pkg::ST_IGNORED;
    wr_en   = 1'b0;
    latch_d = latch_q;
    pair_d  = pair_q;
    entry_d = entry_q;
    op_o    = '0;
    result_o.hit = 1'b0;
    unique case (cmd_i)
      rplu_pkg::CmdStart: begin
        status  = rplu_pkg::ST_OK;
        latch_d = '0;
        pair_d  = 1'b0;
        entry_d = '0;
        op_o.clear = accept_i;
      end
      rplu_pkg::CmdByte: begin
        unique case (phase_q)
          rplu_pkg::PH_HDR_LO: begin
            status  = rplu_pkg::ST_OK;
            latch_d = {7'd0, byte_i};
          end
          rplu_pkg::PH_HDR_HI: begin
            if (hdr == 16'd0) begin
              status = rplu_pkg::ST_END;
            end else begin
              status  = rplu_pkg::ST_OK;
              latch_d = hdr[14:0];
              pair_d  = hdr[15];
            end
          end
          rplu_pkg::PH_DATA1, rplu_pkg::PH_DATA2: begin
            if (!wr_in) begin
              status = rplu_pkg::ST_BADADDR;
            end else begin
              wr_en = 1'b1;
              if (phase_q == rplu_pkg::PH_DATA1 && pair_q) begin
                status = rplu_pkg::ST_OK;
              end else begin
                entry_d = entry_inc;
                status  = limit ? rplu_pkg::ST_LIMIT : rplu_pkg::ST_OK;
              end
            end
          end
          default: status = rplu_pkg::ST_IGNORED;
        endcase
      end
      rplu_pkg::CmdRead: begin
        op_o.rd_en   = accept_i;
        result_o.hit = rd_in && flags_i.rd_written;
        status       = result_o.hit ? rplu_pkg::ST_HIT : rplu_pkg::ST_MISS;
      end
      default: status = rplu_pkg::ST_IGNORED;
    endcase

    op_o.wr_en   = wr_en && accept_i;
    op_o.wr_slot = wr_off[rplu_pkg::SlotMaxW-1:0];
    op_o.wr_data = byte_i;
    op_o.rd_slot = rd_off[rplu_pkg::SlotMaxW-1:0];

    if (cmd_i == rplu_pkg::CmdStart) begin
      total_d = '0;
    end else if (wr_en && !flags_i.wr_written) begin
      total_d = total_q + rplu_pkg::CountW'(1);
    end else begin
      total_d = total_q;
    end

    result_o.status = status;
    result_o.count  = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rplu_pkg::PH_IDLE;
      latch_q <= '0;
      pair_q  <= 1'b0;
      entry_q <= '0;
      total_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      latch_q <= latch_d;
      pair_q  <= pair_d;
      entry_q <= entry_d;
      total_q <= total_d;
    end
  end

endmodule
`default_nettype wire

[rtl/register_preset_list_loader_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// register_preset_list_loader_unit
// Parses a stream of register write records into a shadow register file.
// ----------------------------------------------------------------------------
// channel  | dir | handshake             | payload
// s_axis   | in  | s_axis_tvalid/tready  | tuser cmd, tdata byte + query address
// m_axis   | out | m_axis_tvalid/tready  | tuser status, tdata value + count
// cfg      | in  | cfg_valid_i/ready_o   | cfg_data_i reg_base
//
// One word in per cycle while m_axis is not stalled, one result per word.
// Results pass the memory read stage, then the output register.
// Reset clears phase, counters and written marks and loads the default
// reg_base; no clearing pass.
// Start clears the written marks at once, in flops.
// With m_axis stalled the block takes one more word, held in the read stage.
// ----------------------------------------------------------------------------
module register_preset_list_loader_unit #(
  parameter int unsigned REG_COUNT   = rplu_pkg::RegCountDef,
  parameter int unsigned MAX_ENTRIES = rplu_pkg::MaxEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] byte_value, [23:8] query_address
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] read_value, [14:8] written_count
  output logic [2:0]       m_axis_tuser,   // [2:0] status
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [14:0] cfg_data_i
);

  logic [14:0]            reg_base_q;
  logic                   accept;
  rplu_pkg::store_op_t    op;
  rplu_pkg::store_flags_t flags;
  rplu_pkg::result_t      result;
  logic [7:0]             rd_data;

  logic                        s1_valid_q;
  rplu_pkg::result_t           s1_q;
  logic                        o_valid_q;
  logic [2:0]                  o_status_q;
  logic [7:0]                  o_value_q;
  logic [rplu_pkg::CountW-1:0] o_count_q;
  logic                        o_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_base_q <= rplu_pkg::RegBaseReset;
    end else if (cfg_valid_i) begin
      reg_base_q <= cfg_data_i;
    end
  end

  assign o_load        = s1_valid_q && (!o_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || !o_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rplu_parser #(
    .REG_COUNT  (REG_COUNT),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .cmd_i     (s_axis_tuser),
    .byte_i    (s_axis_tdata[7:0]),
    .qaddr_i   (s_axis_tdata[23:8]),
    .reg_base_i(reg_base_q),
    .flags_i   (flags),
    .op_o      (op),
    .result_o  (result)
  );

  rplu_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .flags_o  (flags),
    .rd_data_o(rd_data)
  );

  // read stage: waits for the memory read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (o_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= result;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_load) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_load) begin
      o_status_q <= s1_q.status;
      o_value_q  <= s1_q.hit ? rd_data : 8'd0;
      o_count_q  <= s1_q.count;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_status_q;
  assign m_axis_tdata  = {1'b0, o_count_q, o_value_q};

endmodule
`default_nettype wire
